// ===== rtl/core/tsc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsc_pkg
// Shared types, codes and helpers for the Maclaurin sine/cosine/tangent/cotangent block.
// ----------------------------------------------------------------------------
package tsc_pkg;

    // operation codes
    localparam logic [1:0] KIND_SIN = 2'd0;
    localparam logic [1:0] KIND_COS = 2'd1;
    localparam logic [1:0] KIND_TAN = 2'd2;
    localparam logic [1:0] KIND_COT = 2'd3;

    // divider: 23 integer and 25 fraction quotient bits, one per cell
    localparam int DIV_STEPS = 48;
    localparam int REM_W     = 88;

    localparam logic [47:0] VAL_MAXPOS = 48'h7FFF_FFFF_FFFF;
    localparam logic [47:0] VAL_MINNEG = 48'h8000_0000_0000;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] angle;
        logic        neg;
        logic [63:0] x2;      // |x|^2 in Q56
    } tsc_side_t;

    typedef struct packed {
        logic [63:0] m;       // term magnitude, Q40
        logic [63:0] s;       // running sum, two's complement Q40
    } tsc_lane_t;

    typedef struct packed {
        logic [REM_W-1:0]     rem;
        logic [REM_W-1:0]     den;
        logic [DIV_STEPS-1:0] quo;
    } tsc_div_t;

    typedef struct packed {
        logic [31:0] angle;
        logic        trig;    // plain sine or cosine
        logic [47:0] tval;
        logic        tsat;
        logic        zero;
        logic        dsat;
        logic        qneg;
    } tsc_fin_t;

    typedef struct packed {
        logic [47:0] value;
        logic        sat;
    } tsc_clip_t;

    function automatic logic [63:0] mag64(input logic [63:0] v);
        return v[63] ? (~v + 64'd1) : v;
    endfunction

    // signed magnitude to Q23.24, clipped
    function automatic tsc_clip_t clip_q24(input logic neg, input logic [63:0] mag);
        tsc_clip_t res;
        res.sat   = 1'b0;
        res.value = neg ? (~mag[47:0] + 48'd1) : mag[47:0];
        if (!neg && mag > {16'd0, VAL_MAXPOS})
        begin
            res.sat   = 1'b1;
            res.value = VAL_MAXPOS;
        end
        else if (neg && mag > {16'd0, VAL_MINNEG})
        begin
            res.sat   = 1'b1;
            res.value = VAL_MINNEG;
        end
        return res;
    endfunction

endpackage

// ===== rtl/core/tsc_mul.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsc_mul
// Two-stage unsigned 64x64 multiplier: four 32x32 products, then their sum.
// ----------------------------------------------------------------------------
module tsc_mul (
    input  logic         clk,
    input  logic         en,
    input  logic [63:0]  a,
    input  logic [63:0]  b,
    output logic [127:0] p
);

    logic [63:0]  pp00_reg, pp01_reg, pp10_reg, pp11_reg;
    logic [127:0] p_reg;
    logic [127:0] p_next;

    assign p_next = {64'd0, pp00_reg} + {32'd0, pp01_reg, 32'd0}
                  + {32'd0, pp10_reg, 32'd0} + {pp11_reg, 64'd0};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pp00_reg <= 64'(a[31:0])  * 64'(b[31:0]);
            pp01_reg <= 64'(a[31:0])  * 64'(b[63:32]);
            pp10_reg <= 64'(a[63:32]) * 64'(b[31:0]);
            pp11_reg <= 64'(a[63:32]) * 64'(b[63:32]);
            p_reg    <= p_next;
        end
    end

    assign p = p_reg;

endmodule

// ===== rtl/core/tsc_term_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsc_term_cell
// One series step for both lanes: next term = round(round(m*x2/2^56)/d),
// added to the running sum with alternating sign. Six stages.
// ----------------------------------------------------------------------------
module tsc_term_cell #(
    parameter int IDX = 0
) (
    input  logic              clk,
    input  logic              en,
    input  tsc_pkg::tsc_side_t side,
    input  tsc_pkg::tsc_lane_t sin_lane,
    input  tsc_pkg::tsc_lane_t cos_lane,
    output tsc_pkg::tsc_side_t side_fwd,
    output tsc_pkg::tsc_lane_t sin_fwd,
    output tsc_pkg::tsc_lane_t cos_fwd
);

    // odd terms take the subtraction
    localparam logic NEG_TERM = ((IDX % 2) == 0);

    tsc_pkg::tsc_lane_t lane_in  [2];
    tsc_pkg::tsc_lane_t lane_out [2];
    tsc_pkg::tsc_side_t side_dly_reg [6];

    assign lane_in[0] = sin_lane;
    assign lane_in[1] = cos_lane;

    for (genvar g = 0; g < 2; g++)
    begin : g_lane
        localparam int D  = (g == 0) ? (2*IDX+2)*(2*IDX+3) : (2*IDX+1)*(2*IDX+2);
        localparam int L  = $clog2(D);
        localparam int SH = 60 + L;
        // exact reciprocal for dividends below 2^60
        localparam logic [127:0] RECIP =
            ((128'd1 << SH) + 128'(D) - 128'd1) / 128'(D);
        localparam logic [63:0] HALF = 64'(D / 2);

        logic [127:0] prod_a, prod_b, rnd, shifted;
        logic [63:0]  n_reg, n_next;
        logic [63:0]  s_dly_reg [5];
        logic [63:0]  m_out_reg, s_out_reg, m_next, s_next;

        tsc_mul u_mx (.clk(clk), .en(en), .a(lane_in[g].m), .b(side.x2), .p(prod_a));

        assign rnd    = prod_a + (128'd1 << 55);
        assign n_next = rnd[119:56] + HALF;

        tsc_mul u_nr (.clk(clk), .en(en), .a(n_reg), .b(RECIP[63:0]), .p(prod_b));

        assign shifted = prod_b >> SH;
        assign m_next  = shifted[63:0];
        assign s_next  = NEG_TERM ? (s_dly_reg[4] - m_next) : (s_dly_reg[4] + m_next);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                n_reg        <= n_next;
                s_dly_reg[0] <= lane_in[g].s;
                for (int k = 1; k < 5; k++)
                begin
                    s_dly_reg[k] <= s_dly_reg[k-1];
                end
                m_out_reg    <= m_next;
                s_out_reg    <= s_next;
            end
        end

        assign lane_out[g].m = m_out_reg;
        assign lane_out[g].s = s_out_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_dly_reg[0] <= side;
            for (int k = 1; k < 6; k++)
            begin
                side_dly_reg[k] <= side_dly_reg[k-1];
            end
        end
    end

    assign side_fwd = side_dly_reg[5];
    assign sin_fwd  = lane_out[0];
    assign cos_fwd  = lane_out[1];

endmodule

// ===== rtl/core/tsc_div_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsc_div_cell
// One restoring division step: trial subtract, keep or restore, shift.
// ----------------------------------------------------------------------------
module tsc_div_cell (
    input  logic              clk,
    input  logic              en,
    input  tsc_pkg::tsc_div_t step,
    input  tsc_pkg::tsc_fin_t fin,
    output tsc_pkg::tsc_div_t step_fwd,
    output tsc_pkg::tsc_fin_t fin_fwd
);

    logic [tsc_pkg::REM_W:0]   diff;
    logic                      ge;
    logic [tsc_pkg::REM_W-1:0] rem_sel;
    tsc_pkg::tsc_div_t         step_reg, step_next;
    tsc_pkg::tsc_fin_t         fin_reg;

    always_comb
    begin
        diff      = {1'b0, step.rem} - {1'b0, step.den};
        ge        = !diff[tsc_pkg::REM_W];
        rem_sel   = ge ? diff[tsc_pkg::REM_W-1:0] : step.rem;
        step_next.rem = {rem_sel[tsc_pkg::REM_W-2:0], 1'b0};
        step_next.den = step.den;
        step_next.quo = {step.quo[tsc_pkg::DIV_STEPS-2:0], ge};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            step_reg <= step_next;
            fin_reg  <= fin;
        end
    end

    assign step_fwd = step_reg;
    assign fin_fwd  = fin_reg;

endmodule

// ===== rtl/core/taylor_sin_cos_tan_cot.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// taylor_sin_cos_tan_cot
// Fixed-point sine, cosine, tangent and cotangent by Maclaurin series.
// ----------------------------------------------------------------------------
// One request is taken in every cycle while the result side keeps up; each
// request gives exactly one result, in order. Most of the pipeline is the
// chain of term cells, six stages each (two split 64x64 multiplies and a
// rounding step), and the 48-cell restoring divider that follows. The
// argument is Q3.28 radians and is used without range reduction; the result
// is Q23.24. Both series are always evaluated; tangent and cotangent divide
// one by the other. A result beyond range clips and raises saturated; a zero
// divisor gives zero and raises zero_divisor. The whole pipeline holds only
// while a finished result waits and the result side stalls.
// ----------------------------------------------------------------------------
module taylor_sin_cos_tan_cot #(
    parameter int TERMS = 11
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               arg_valid,
    output logic               arg_stall,
    input  logic [1:0]         kind,
    input  logic signed [31:0] angle,
    output logic               res_valid,
    input  logic               res_stall,
    output logic signed [31:0] angle_echo,
    output logic signed [47:0] value,
    output logic               saturated,
    output logic               zero_divisor
);

    localparam int NSTG = 4 + 6*(TERMS-1) + tsc_pkg::DIV_STEPS;

    logic            adv;
    logic [NSTG-1:0] vld_reg, vld_next;
    logic            res_valid_reg;

    // advance everything unless a finished result is held back
    assign adv       = !res_valid_reg || !res_stall;
    assign arg_stall = !adv;
    assign vld_next  = {vld_reg[NSTG-2:0], arg_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg       <= vld_next;
            res_valid_reg <= vld_reg[NSTG-1];
        end
    end

    // ---- capture stage: take the magnitude of the argument ----
    logic [1:0]  kind_reg;
    logic [31:0] angle_reg, mag_reg, mag_next;
    logic        neg_reg;

    assign mag_next = angle[31] ? (~angle + 32'd1) : angle;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            kind_reg  <= kind;
            angle_reg <= angle;
            neg_reg   <= angle[31];
            mag_reg   <= mag_next;
        end
    end

    // ---- seed stage: square, first terms ----
    tsc_pkg::tsc_side_t side_c [TERMS];
    tsc_pkg::tsc_lane_t sin_c  [TERMS];
    tsc_pkg::tsc_lane_t cos_c  [TERMS];
    tsc_pkg::tsc_side_t seed_side_reg;
    tsc_pkg::tsc_lane_t seed_sin_reg, seed_cos_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            seed_side_reg.kind  <= kind_reg;
            seed_side_reg.angle <= angle_reg;
            seed_side_reg.neg   <= neg_reg;
            seed_side_reg.x2    <= 64'(mag_reg) * 64'(mag_reg);
            seed_sin_reg.m      <= {20'd0, mag_reg, 12'd0};
            seed_sin_reg.s      <= {20'd0, mag_reg, 12'd0};
            seed_cos_reg.m      <= 64'd1 << 40;
            seed_cos_reg.s      <= 64'd1 << 40;
        end
    end

    assign side_c[0] = seed_side_reg;
    assign sin_c[0]  = seed_sin_reg;
    assign cos_c[0]  = seed_cos_reg;

    // ---- chain of term cells, one per further series term ----
    for (genvar i = 0; i < TERMS-1; i++)
    begin : g_term
        tsc_term_cell #(.IDX(i)) u_term (
            .clk      (clk),
            .en       (adv),
            .side     (side_c[i]),
            .sin_lane (sin_c[i]),
            .cos_lane (cos_c[i]),
            .side_fwd (side_c[i+1]),
            .sin_fwd  (sin_c[i+1]),
            .cos_fwd  (cos_c[i+1])
        );
    end

    // ---- select stage: sign the sine, pick numerator and divisor ----
    tsc_pkg::tsc_side_t sd;
    logic [63:0] sn, cs, num, den, tsum;
    logic [31:0] sel_angle_reg;
    logic        sel_trig_reg, sel_qneg_reg, sel_zero_reg;
    logic [63:0] sel_tsum_reg, sel_nmag_reg, sel_dmag_reg;

    always_comb
    begin
        sd   = side_c[TERMS-1];
        cs   = cos_c[TERMS-1].s;
        sn   = sd.neg ? (~sin_c[TERMS-1].s + 64'd1) : sin_c[TERMS-1].s;
        num  = (sd.kind == tsc_pkg::KIND_COT) ? cs : sn;
        den  = (sd.kind == tsc_pkg::KIND_COT) ? sn : cs;
        tsum = (sd.kind == tsc_pkg::KIND_SIN) ? sn : cs;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sel_angle_reg <= sd.angle;
            sel_trig_reg  <= sd.kind inside {tsc_pkg::KIND_SIN, tsc_pkg::KIND_COS};
            sel_tsum_reg  <= tsum;
            sel_nmag_reg  <= tsc_pkg::mag64(num);
            sel_dmag_reg  <= tsc_pkg::mag64(den);
            sel_qneg_reg  <= num[63] ^ den[63];
            sel_zero_reg  <= (den == 64'd0);
        end
    end

    // ---- prepare stage: round plain results, range-check the quotient ----
    logic [63:0]        trnd;
    tsc_pkg::tsc_clip_t tclip;
    logic               dsat;
    tsc_pkg::tsc_div_t  step_c [tsc_pkg::DIV_STEPS+1];
    tsc_pkg::tsc_fin_t  fin_c  [tsc_pkg::DIV_STEPS+1];
    tsc_pkg::tsc_div_t  prep_step_reg;
    tsc_pkg::tsc_fin_t  prep_fin_reg;

    always_comb
    begin
        trnd  = tsc_pkg::mag64(sel_tsum_reg) + (64'd1 << 15);
        tclip = tsc_pkg::clip_q24(sel_tsum_reg[63], {16'd0, trnd[63:16]});
        // integer part of the quotient must stay below 2^23
        dsat  = {23'd0, sel_nmag_reg} >= {sel_dmag_reg, 23'd0};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            prep_fin_reg.angle <= sel_angle_reg;
            prep_fin_reg.trig  <= sel_trig_reg;
            prep_fin_reg.tval  <= tclip.value;
            prep_fin_reg.tsat  <= tclip.sat;
            prep_fin_reg.zero  <= sel_zero_reg;
            prep_fin_reg.dsat  <= dsat;
            prep_fin_reg.qneg  <= sel_qneg_reg;
            prep_step_reg.rem  <= {24'd0, sel_nmag_reg};
            prep_step_reg.den  <= {2'd0, sel_dmag_reg, 22'd0};
            prep_step_reg.quo  <= '0;
        end
    end

    assign step_c[0] = prep_step_reg;
    assign fin_c[0]  = prep_fin_reg;

    // ---- divider chain: one quotient bit per cell ----
    for (genvar j = 0; j < tsc_pkg::DIV_STEPS; j++)
    begin : g_div
        tsc_div_cell u_div (
            .clk      (clk),
            .en       (adv),
            .step     (step_c[j]),
            .fin      (fin_c[j]),
            .step_fwd (step_c[j+1]),
            .fin_fwd  (fin_c[j+1])
        );
    end

    // ---- output register: round the quotient and pick the result ----
    tsc_pkg::tsc_fin_t  fz;
    logic [48:0]        qr;
    tsc_pkg::tsc_clip_t qclip;
    logic [47:0]        value_next;
    logic               sat_next;
    logic [31:0]        angle_echo_reg;
    logic [47:0]        value_reg;
    logic               saturated_reg, zero_divisor_reg;

    always_comb
    begin
        fz    = fin_c[tsc_pkg::DIV_STEPS];
        qr    = {1'b0, step_c[tsc_pkg::DIV_STEPS].quo} + 49'd1;
        qclip = tsc_pkg::clip_q24(fz.qneg, {16'd0, qr[48:1]});
        if (fz.trig)
        begin
            value_next = fz.tval;
            sat_next   = fz.tsat;
        end
        else if (fz.zero)
        begin
            value_next = '0;
            sat_next   = 1'b0;
        end
        else if (fz.dsat)
        begin
            value_next = fz.qneg ? tsc_pkg::VAL_MINNEG : tsc_pkg::VAL_MAXPOS;
            sat_next   = 1'b1;
        end
        else
        begin
            value_next = qclip.value;
            sat_next   = qclip.sat;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            angle_echo_reg   <= fz.angle;
            value_reg        <= value_next;
            saturated_reg    <= sat_next;
            zero_divisor_reg <= !fz.trig && fz.zero;
        end
    end

    assign res_valid    = res_valid_reg;
    assign angle_echo   = angle_echo_reg;
    assign value        = value_reg;
    assign saturated    = saturated_reg;
    assign zero_divisor = zero_divisor_reg;

    // ---- checks ----
    a_zdiv_clean: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && zero_divisor |-> !saturated && value == 48'sd0)
        else $error("zero divisor with non-zero value or saturation");

    a_sat_rail: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && saturated |->
            value == tsc_pkg::VAL_MAXPOS || value == tsc_pkg::VAL_MINNEG)
        else $error("saturated result not on a rail");

    a_hold_input: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |-> arg_stall)
        else $error("request taken while the pipeline is held");

    a_capture: assert property (@(posedge clk) disable iff (!rst_n)
        arg_valid && !arg_stall |=> vld_reg[0])
        else $error("accepted request not captured");

endmodule

// ===== tb/sv/taylor_sin_cos_tan_cot_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// taylor_sin_cos_tan_cot_test
// Self-checking bench for the Maclaurin sine/cosine/tangent/cotangent block.
// Requests come from a queue and go through a driver with random gaps.
// The predicted value, flags and echoed angle of each accepted request are
// queued. A monitor compares every result with the oldest prediction.
// Once during the run the result side holds off long enough to back the
// pipeline up into the request side.
// ----------------------------------------------------------------------------
module taylor_sin_cos_tan_cot_test;

    localparam int TERMS      = 11;
    localparam int LATENCY    = 4 + 6 * (TERMS - 1) + 48 + 1;
    localparam int IDLE_LIMIT = 20000;
    localparam int RANDOM_REQ = 1530;
    localparam int HOLD_AT    = 700;
    localparam int HOLD_LEN   = 600;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] angle;
    } trig_req_t;

    typedef struct packed {
        logic [31:0] angle_echo;
        logic [47:0] value;
        logic        saturated;
        logic        zero_divisor;
    } trig_res_t;

    logic               clk;
    logic               rst_n;
    logic               arg_valid;
    logic               arg_stall;
    logic [1:0]         kind;
    logic signed [31:0] angle;
    logic               res_valid;
    logic               res_stall;
    logic signed [31:0] angle_echo;
    logic signed [47:0] value;
    logic               saturated;
    logic               zero_divisor;

    trig_req_t pending_reqs[$];
    trig_res_t predicted_results[$];

    int  mismatch_count;
    int  req_taken_count;
    int  idle_cycles;
    bit  req_taken;        // last rising edge accepted a request
    bit  quiet_phase;      // no new random gaps on either side while set
    bit  stimulus_done;

    taylor_sin_cos_tan_cot #(.TERMS(TERMS)) uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .arg_valid    (arg_valid),
        .arg_stall    (arg_stall),
        .kind         (kind),
        .angle        (angle),
        .res_valid    (res_valid),
        .res_stall    (res_stall),
        .angle_echo   (angle_echo),
        .value        (value),
        .saturated    (saturated),
        .zero_divisor (zero_divisor)
    );

    // ------------------------------------------------------------------
    // Predictor: series in Q40 with round-half-away on magnitudes
    // ------------------------------------------------------------------

    // next term: round(round(term * x2 / 2^56) / d)
    function automatic logic [63:0] next_term(input logic [63:0] term,
                                              input logic [63:0] x2,
                                              input logic [63:0] d);
        logic [127:0] prod;
        logic [63:0]  shifted;
        prod    = {64'd0, term} * {64'd0, x2};
        prod    = prod + (128'd1 << 55);
        shifted = prod[119:56];
        return (shifted + d / 2) / d;
    endfunction

    function automatic logic signed [63:0] series_sum(input logic [63:0] mag,
                                                      input logic neg,
                                                      input logic odd);
        logic [63:0]        x2;
        logic [63:0]        term;
        logic [63:0]        d;
        logic signed [63:0] sum;
        logic               plus;
        x2   = mag * mag;
        term = odd ? (mag << 12) : (64'd1 << 40);
        sum  = 64'sd0;
        plus = 1'b1;
        for (int i = 0; i < TERMS; i++)
        begin
            sum = plus ? sum + $signed(term) : sum - $signed(term);
            if (i + 1 < TERMS)
            begin
                d    = odd ? 64'((2 * i + 2) * (2 * i + 3))
                           : 64'((2 * i + 1) * (2 * i + 2));
                term = next_term(term, x2, d);
                plus = !plus;
            end
        end
        if (odd && neg)
            sum = -sum;
        return sum;
    endfunction

    function automatic logic [63:0] abs64(input logic signed [63:0] v);
        return v < 0 ? 64'(-v) : 64'(v);
    endfunction

    function automatic void clip_to_q24(input logic neg, input logic [63:0] mag,
                                        output logic [47:0] val, inout logic sat);
        if (!neg && mag > 64'h7FFF_FFFF_FFFF)
        begin
            sat = 1'b1;
            val = 48'h7FFF_FFFF_FFFF;
        end
        else if (neg && mag > 64'h8000_0000_0000)
        begin
            sat = 1'b1;
            val = 48'h8000_0000_0000;
        end
        else
            val = neg ? 48'(-mag) : mag[47:0];
    endfunction

    function automatic trig_res_t predict_trig(input trig_req_t req);
        trig_res_t          res;
        logic               neg;
        logic [63:0]        mag;
        logic signed [63:0] sn;
        logic signed [63:0] cs;
        logic signed [63:0] num;
        logic signed [63:0] den;
        logic [63:0]        n;
        logic [63:0]        dm;
        logic [63:0]        q;
        logic [63:0]        r;
        logic               qneg;
        logic               sat;
        logic [47:0]        val;
        neg = req.angle[31];
        mag = neg ? (64'd1 << 32) - {32'd0, req.angle} : {32'd0, req.angle};
        sn  = series_sum(mag, neg, 1'b1);
        cs  = series_sum(mag, neg, 1'b0);
        sat = 1'b0;
        res.zero_divisor = 1'b0;
        val = 48'd0;
        if (req.kind == tsc_pkg::KIND_SIN || req.kind == tsc_pkg::KIND_COS)
        begin
            num = (req.kind == tsc_pkg::KIND_SIN) ? sn : cs;
            clip_to_q24(num < 0, (abs64(num) + (64'd1 << 15)) >> 16, val, sat);
        end
        else
        begin
            num = (req.kind == tsc_pkg::KIND_TAN) ? sn : cs;
            den = (req.kind == tsc_pkg::KIND_TAN) ? cs : sn;
            if (den == 0)
                res.zero_divisor = 1'b1;
            else
            begin
                n    = abs64(num);
                dm   = abs64(den);
                qneg = (num < 0) != (den < 0);
                q    = n / dm;
                r    = n % dm;
                if (q >= (64'd1 << 23))
                begin
                    sat = 1'b1;
                    val = qneg ? 48'h8000_0000_0000 : 48'h7FFF_FFFF_FFFF;
                end
                else
                begin
                    for (int k = 0; k < 24; k++)
                    begin
                        r = r << 1;
                        q = q << 1;
                        if (r >= dm)
                        begin
                            r = r - dm;
                            q = q | 64'd1;
                        end
                    end
                    if (2 * r >= dm)
                        q = q + 1;
                    clip_to_q24(qneg, q, val, sat);
                end
            end
        end
        res.angle_echo = req.angle;
        res.value      = val;
        res.saturated  = sat;
        return res;
    endfunction

    // mostly no gap, some short, a few long
    function automatic int gap_length();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 60)
            return 0;
        if (pick < 90)
            return $urandom_range(1, 3);
        if (pick < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    // ------------------------------------------------------------------
    // Clock and reset
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
    end

    // ------------------------------------------------------------------
    // Request driver: change inputs at the falling edge only
    // ------------------------------------------------------------------
    int arg_gap;

    initial
    begin
        arg_valid = 1'b0;
        kind      = tsc_pkg::KIND_SIN;
        angle     = '0;
        arg_gap   = 0;
    end

    always @(negedge clk)
    begin
        if (rst_n && (!arg_valid || req_taken))
        begin
            // the held request has gone, or nothing is offered: pick the next
            if (arg_gap > 0)
            begin
                arg_gap   <= arg_gap - 1;
                arg_valid <= 1'b0;
            end
            else if (pending_reqs.size() > 0)
            begin
                trig_req_t req;
                req = pending_reqs.pop_front();
                arg_valid <= 1'b1;
                kind      <= req.kind;
                angle     <= req.angle;
                arg_gap   <= quiet_phase ? 0 : gap_length();
            end
            else
                arg_valid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Result side stall: random gaps plus one long hold-off
    // ------------------------------------------------------------------
    int  res_gap;
    int  hold_count;
    bit  hold_done;

    initial
    begin
        res_stall  = 1'b0;
        res_gap    = 0;
        hold_count = 0;
        hold_done  = 1'b0;
    end

    always @(negedge clk)
    begin
        if (!hold_done && req_taken_count >= HOLD_AT)
        begin
            // hold the result side while the sender keeps offering requests
            hold_done  <= 1'b1;
            hold_count <= HOLD_LEN;
            res_stall  <= 1'b1;
        end
        else if (hold_count > 0)
        begin
            hold_count <= hold_count - 1;
            res_stall  <= 1'b1;
        end
        else if (res_gap > 0)
        begin
            res_gap   <= res_gap - 1;
            res_stall <= 1'b1;
        end
        else
        begin
            res_stall <= 1'b0;
            res_gap   <= quiet_phase ? 0 : gap_length();
        end
    end

    // ------------------------------------------------------------------
    // Monitor: sample at the rising edge, predict on accept, check results
    // ------------------------------------------------------------------
    initial
    begin
        mismatch_count  = 0;
        req_taken_count = 0;
        idle_cycles     = 0;
        req_taken       = 1'b0;
    end

    always @(posedge clk)
    begin
        bit moved;
        moved = 1'b0;
        req_taken <= rst_n && arg_valid && !arg_stall;
        if (rst_n && arg_valid && !arg_stall)
        begin
            trig_req_t req;
            req.kind  = kind;
            req.angle = angle;
            predicted_results.push_back(predict_trig(req));
            req_taken_count <= req_taken_count + 1;
            moved = 1'b1;
        end
        if (rst_n && res_valid && !res_stall)
        begin
            trig_res_t got;
            trig_res_t want;
            moved          = 1'b1;
            got.angle_echo   = angle_echo;
            got.value        = value;
            got.saturated    = saturated;
            got.zero_divisor = zero_divisor;
            if (predicted_results.size() == 0)
            begin
                mismatch_count <= mismatch_count + 1;
                if (mismatch_count < 10)
                    $display("unexpected result: echo %h value %h sat %b zdiv %b",
                             got.angle_echo, got.value, got.saturated,
                             got.zero_divisor);
            end
            else
            begin
                want = predicted_results.pop_front();
                if (got !== want)
                begin
                    mismatch_count <= mismatch_count + 1;
                    if (mismatch_count < 10)
                        $display({"mismatch: expected echo %h value %h sat %b zdiv %b,",
                                  " got echo %h value %h sat %b zdiv %b"},
                                 want.angle_echo, want.value, want.saturated,
                                 want.zero_divisor, got.angle_echo, got.value,
                                 got.saturated, got.zero_divisor);
                end
            end
        end
        // watchdog: count cycles in which nothing moves on either side
        if (!rst_n || moved || (stimulus_done && predicted_results.size() == 0))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("taylor_sin_cos_tan_cot_test: done, errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------
    function automatic logic [31:0] random_angle();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 55)
            return 32'($signed($urandom_range(0, 32'h6000_0000)) - 32'sh3000_0000);
        if (pick < 75)
            return 32'($signed($urandom_range(0, 32'h0100_0000)) - 32'sh0080_0000);
        if (pick < 80)
            return 32'($signed($urandom_range(0, 32)) - 16);
        return $urandom();
    endfunction

    initial
    begin
        logic [31:0] edge_angles[$];
        trig_req_t   req;
        stimulus_done = 1'b0;
        quiet_phase   = 1'b0;
        // zero (cotangent divisor zero), smallest steps, about pi/2, minus pi/2 and pi,
        // and both ends of the range
        edge_angles = '{32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF,
                        32'h1921_FB54, 32'hE6DE_04AC, 32'h3243_F6A9,
                        32'h7FFF_FFFF, 32'h8000_0000};
        foreach (edge_angles[a])
        begin
            for (int k = 0; k < 4; k++)
            begin
                if (a < 2 || a == 3 || a == 6 || a == 7 || k >= 2)
                begin
                    req.kind  = 2'(k);
                    req.angle = edge_angles[a];
                    pending_reqs.push_back(req);
                end
            end
        end
        for (int n = 0; n < RANDOM_REQ; n++)
        begin
            req.kind  = 2'($urandom_range(0, 3));
            req.angle = random_angle();
            pending_reqs.push_back(req);
        end
        @(posedge rst_n);
        // alternate stretches with and without idling
        while (pending_reqs.size() > 0 || arg_valid)
        begin
            repeat (150) @(posedge clk);
            quiet_phase = ($urandom_range(0, 3) == 0);
        end
        quiet_phase   = 1'b0;
        stimulus_done = 1'b1;
        wait (predicted_results.size() == 0);
        repeat (LATENCY + 20) @(posedge clk);
        if (mismatch_count == 0 && predicted_results.size() == 0)
            $display("taylor_sin_cos_tan_cot_test: done, clean");
        else
            $display("taylor_sin_cos_tan_cot_test: done, errors");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/tsc_pkg.sv
rtl/core/tsc_mul.sv
rtl/core/tsc_term_cell.sv
rtl/core/tsc_div_cell.sv
rtl/core/taylor_sin_cos_tan_cot.sv
tb/sv/taylor_sin_cos_tan_cot_test.sv
